>>> hw/rtl/bvp_pkg.sv
// Shared constants and types for the battery voltage to percent estimator.
package bvp_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W = 20;
  localparam int COUNT_W = 8;
  localparam int GAIN_W = 16;
  localparam int VOLT_W = 13;
  localparam int PCT_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_BURST = 255;
  localparam int CURVE_POINTS = 9;
  localparam int POINT_W = $clog2(CURVE_POINTS);
  localparam int SEG_W = $clog2(CURVE_POINTS - 1);

  localparam int MUL_A_W = SUM_W;
  localparam int MUL_B_W = GAIN_W;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int HALF_W = PROD_W / 2;
  localparam int PART_W = HALF_W + GAIN_W;
  localparam int FULL_W = PROD_W + GAIN_W;
  localparam int FRAC_SHIFT = 24;
  localparam int QUOT_W = FULL_W - FRAC_SHIFT;
  localparam int DIVISOR_W = 9;
  localparam int REM_W = DIVISOR_W;
  localparam int STEP_W = $clog2(QUOT_W);
  localparam int INTERP_W = 13;
  localparam int TERM_USED_W = INTERP_W - 1;

  localparam logic [STEP_W-1:0] MV_DIV_LAST = STEP_W'(QUOT_W - 1);
  localparam logic [STEP_W-1:0] PCT_DIV_LAST = STEP_W'(INTERP_W - 1);

  localparam logic [VOLT_W-1:0] MV_LOW = 13'd2900;
  localparam logic [VOLT_W-1:0] MV_HIGH = 13'd4350;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 8'd16;
  localparam logic [GAIN_W-1:0] DIVIDER_GAIN_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] CALIBRATION_GAIN_RST = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION_GAIN = 2'd2;

  localparam logic [VOLT_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
    13'd3700, 13'd3600, 13'd3450, 13'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd65, 7'd50, 7'd30, 7'd15, 7'd5, 7'd0
  };

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_MUL0    = 12'b0000_0000_0010,
    ST_MUL1    = 12'b0000_0000_0100,
    ST_MUL2    = 12'b0000_0000_1000,
    ST_ADD     = 12'b0000_0001_0000,
    ST_DIV_MV  = 12'b0000_0010_0000,
    ST_CHECK   = 12'b0000_0100_0000,
    ST_MUL3    = 12'b0000_1000_0000,
    ST_LOAD    = 12'b0001_0000_0000,
    ST_DIV_PCT = 12'b0010_0000_0000,
    ST_PCT     = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_t;

endpackage

>>> hw/rtl/battery_voltage_to_percent.sv
// Top level: burst averaging of ADC samples and LiPo state-of-charge lookup.
// A sample word that does not end a burst is taken with no result.
// A burst-ending word gives its result word by way of the states MUL0 to DONE, through the
// 28-step and 13-step passes of the shared restoring divider; the second pass is skipped
// when the voltage is off range or at a curve end, and with no valid sample it goes to DONE.
// Synchronous reset restores the register defaults and clears all burst and held values.
module battery_voltage_to_percent (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] adc_millivolts
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [12:0] battery_millivolts, [19:13] charge_percent
  output logic [0:0]  m_tuser,   // [0] reading_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bvp_pkg::state_t state;

  logic [bvp_pkg::COUNT_W-1:0] sample_count;
  logic [bvp_pkg::GAIN_W-1:0] divider_gain;
  logic [bvp_pkg::GAIN_W-1:0] calibration_gain;

  logic [bvp_pkg::SUM_W-1:0] burst_sum;
  logic [bvp_pkg::COUNT_W-1:0] burst_index;
  logic [bvp_pkg::COUNT_W-1:0] good_count;
  logic [bvp_pkg::VOLT_W-1:0] held_millivolts;
  logic [bvp_pkg::PCT_W-1:0] held_percent;

  logic [bvp_pkg::PROD_W-1:0] term;
  logic [bvp_pkg::PART_W-1:0] part_lo;
  logic [bvp_pkg::PART_W-1:0] part_hi;
  logic [bvp_pkg::QUOT_W-1:0] dvd;
  logic [bvp_pkg::DIVISOR_W-1:0] dvs;
  logic [bvp_pkg::REM_W-1:0] rem;
  logic [bvp_pkg::STEP_W-1:0] steps;
  logic [bvp_pkg::VOLT_W-1:0] mv;
  logic [bvp_pkg::PCT_W-1:0] pct;
  logic mv_ok;
  logic [bvp_pkg::SEG_W-1:0] seg;

  logic out_ok;
  logic [bvp_pkg::VOLT_W-1:0] out_mv;
  logic [bvp_pkg::PCT_W-1:0] out_pct;

  logic [bvp_pkg::SAMPLE_W-1:0] sample;
  logic sample_good;
  logic [bvp_pkg::COUNT_W-1:0] count_eff;
  logic [bvp_pkg::COUNT_W-1:0] index_inc;
  logic [bvp_pkg::COUNT_W-1:0] good_inc;
  logic burst_end;

  logic [bvp_pkg::MUL_A_W-1:0] mul_a;
  logic [bvp_pkg::MUL_B_W-1:0] mul_b;
  logic [bvp_pkg::PROD_W-1:0] mul_out;
  logic [bvp_pkg::FULL_W-1:0] full_sum;

  logic [bvp_pkg::REM_W:0] rem_sh;
  logic div_ge;
  logic [bvp_pkg::REM_W-1:0] rem_new;

  logic in_range;
  logic [bvp_pkg::SEG_W-1:0] seg_found;
  logic [bvp_pkg::POINT_W-1:0] hi_pt;
  logic [bvp_pkg::POINT_W-1:0] lo_pt;
  logic [bvp_pkg::VOLT_W-1:0] seg_dv;
  logic [bvp_pkg::INTERP_W-1:0] interp_num;
  logic out_free;

  assign s_tready = (state == bvp_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata = {4'd0, out_pct, out_mv};
  assign m_tuser = out_ok;

  assign sample = s_tdata[bvp_pkg::SAMPLE_W-1:0];
  assign sample_good = (sample != '0);
  assign count_eff = (sample_count == '0) ? bvp_pkg::COUNT_W'(1) : sample_count;
  assign index_inc = burst_index + bvp_pkg::COUNT_W'(1);
  assign good_inc = good_count + bvp_pkg::COUNT_W'(sample_good);
  assign burst_end = (index_inc >= count_eff);
  assign out_free = !m_tvalid || m_tready;

  assign hi_pt = bvp_pkg::POINT_W'(seg);
  assign lo_pt = bvp_pkg::POINT_W'(seg) + bvp_pkg::POINT_W'(1);
  assign seg_dv = bvp_pkg::CURVE_MV[hi_pt] - bvp_pkg::CURVE_MV[lo_pt];
  assign interp_num = {term[bvp_pkg::TERM_USED_W-1:0], 1'b0} + bvp_pkg::INTERP_W'(seg_dv);

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      bvp_pkg::ST_MUL0: begin
        mul_a = burst_sum;
        mul_b = divider_gain;
      end
      bvp_pkg::ST_MUL1: begin
        mul_a = bvp_pkg::MUL_A_W'(term[bvp_pkg::HALF_W-1:0]);
        mul_b = calibration_gain;
      end
      bvp_pkg::ST_MUL2: begin
        mul_a = bvp_pkg::MUL_A_W'(term[bvp_pkg::PROD_W-1:bvp_pkg::HALF_W]);
        mul_b = calibration_gain;
      end
      bvp_pkg::ST_MUL3: begin
        mul_a = bvp_pkg::MUL_A_W'(mv - bvp_pkg::CURVE_MV[lo_pt]);
        mul_b = bvp_pkg::MUL_B_W'(bvp_pkg::CURVE_PCT[hi_pt] - bvp_pkg::CURVE_PCT[lo_pt]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;
  assign full_sum = {part_hi, {bvp_pkg::HALF_W{1'b0}}} + bvp_pkg::FULL_W'(part_lo);

  // One restoring division step.
  assign rem_sh = {rem, dvd[bvp_pkg::QUOT_W-1]};
  assign div_ge = (rem_sh >= {1'b0, dvs});
  assign rem_new = div_ge ? bvp_pkg::REM_W'(rem_sh - {1'b0, dvs})
                          : rem_sh[bvp_pkg::REM_W-1:0];

  assign in_range = (dvd >= bvp_pkg::QUOT_W'(bvp_pkg::MV_LOW)) &&
                    (dvd <= bvp_pkg::QUOT_W'(bvp_pkg::MV_HIGH));

  // The first curve segment whose lower point lies at or below the voltage.
  always_comb begin
    seg_found = '0;
    for (int i = bvp_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
      if (dvd[bvp_pkg::VOLT_W-1:0] >= bvp_pkg::CURVE_MV[i+1]) begin
        seg_found = bvp_pkg::SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvp_pkg::ST_IDLE;
      sample_count <= bvp_pkg::SAMPLE_COUNT_RST;
      divider_gain <= bvp_pkg::DIVIDER_GAIN_RST;
      calibration_gain <= bvp_pkg::CALIBRATION_GAIN_RST;
      burst_sum <= '0;
      burst_index <= '0;
      good_count <= '0;
      held_millivolts <= '0;
      held_percent <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bvp_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[bvp_pkg::COUNT_W-1:0];
          bvp_pkg::REG_DIVIDER_GAIN: divider_gain <= cfg_data;
          bvp_pkg::REG_CALIBRATION_GAIN: calibration_gain <= cfg_data;
          default: ;
        endcase
      end

      if (state == bvp_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        bvp_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            if (sample_good) begin
              burst_sum <= burst_sum + bvp_pkg::SUM_W'(sample);
            end
            good_count <= good_inc;
            burst_index <= index_inc;
            if (burst_end) begin
              mv_ok <= 1'b0;
              state <= (good_inc != '0) ? bvp_pkg::ST_MUL0 : bvp_pkg::ST_DONE;
            end
          end
        end
        bvp_pkg::ST_MUL0: begin
          term <= mul_out;
          state <= bvp_pkg::ST_MUL1;
        end
        bvp_pkg::ST_MUL1: begin
          part_lo <= mul_out[bvp_pkg::PART_W-1:0];
          state <= bvp_pkg::ST_MUL2;
        end
        bvp_pkg::ST_MUL2: begin
          part_hi <= mul_out[bvp_pkg::PART_W-1:0];
          state <= bvp_pkg::ST_ADD;
        end
        bvp_pkg::ST_ADD: begin
          dvd <= full_sum[bvp_pkg::FULL_W-1:bvp_pkg::FRAC_SHIFT];
          dvs <= bvp_pkg::DIVISOR_W'(good_count);
          rem <= '0;
          steps <= bvp_pkg::MV_DIV_LAST;
          state <= bvp_pkg::ST_DIV_MV;
        end
        bvp_pkg::ST_DIV_MV, bvp_pkg::ST_DIV_PCT: begin
          dvd <= {dvd[bvp_pkg::QUOT_W-2:0], div_ge};
          rem <= rem_new;
          steps <= steps - bvp_pkg::STEP_W'(1);
          if (steps == '0) begin
            state <= (state == bvp_pkg::ST_DIV_MV) ? bvp_pkg::ST_CHECK : bvp_pkg::ST_PCT;
          end
        end
        bvp_pkg::ST_CHECK: begin
          mv <= dvd[bvp_pkg::VOLT_W-1:0];
          seg <= seg_found;
          mv_ok <= in_range;
          if (!in_range) begin
            state <= bvp_pkg::ST_DONE;
          end else if (dvd >= bvp_pkg::QUOT_W'(bvp_pkg::CURVE_MV[0])) begin
            pct <= bvp_pkg::CURVE_PCT[0];
            state <= bvp_pkg::ST_DONE;
          end else if (dvd <= bvp_pkg::QUOT_W'(bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1]))
          begin
            pct <= bvp_pkg::CURVE_PCT[bvp_pkg::CURVE_POINTS-1];
            state <= bvp_pkg::ST_DONE;
          end else begin
            state <= bvp_pkg::ST_MUL3;
          end
        end
        bvp_pkg::ST_MUL3: begin
          term <= mul_out;
          state <= bvp_pkg::ST_LOAD;
        end
        bvp_pkg::ST_LOAD: begin
          dvd <= {interp_num, {(bvp_pkg::QUOT_W - bvp_pkg::INTERP_W){1'b0}}};
          dvs <= bvp_pkg::DIVISOR_W'({seg_dv, 1'b0});
          rem <= '0;
          steps <= bvp_pkg::PCT_DIV_LAST;
          state <= bvp_pkg::ST_DIV_PCT;
        end
        bvp_pkg::ST_PCT: begin
          pct <= bvp_pkg::CURVE_PCT[lo_pt] + dvd[bvp_pkg::PCT_W-1:0];
          state <= bvp_pkg::ST_DONE;
        end
        bvp_pkg::ST_DONE: begin
          if (out_free) begin
            out_ok <= mv_ok;
            out_mv <= mv_ok ? mv : held_millivolts;
            out_pct <= mv_ok ? pct : held_percent;
            if (mv_ok) begin
              held_millivolts <= mv;
              held_percent <= pct;
            end
            burst_sum <= '0;
            burst_index <= '0;
            good_count <= '0;
            state <= bvp_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bvp_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_valid_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (out_mv >= bvp_pkg::MV_LOW && out_mv <= bvp_pkg::MV_HIGH))
    else $error("valid reading outside the accepted voltage range");

  a_pct_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_pct <= bvp_pkg::PCT_FULL))
    else $error("charge percent above full");

  a_hold_on_invalid: assert property (@(posedge clk) disable iff (rst)
    (state == bvp_pkg::ST_DONE && out_free && !mv_ok) |=>
      (held_millivolts == $past(held_millivolts) && m_tdata[12:0] == held_millivolts))
    else $error("held voltage changed on an invalid reading");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bvp_pkg::ST_DIV_MV || state == bvp_pkg::ST_DIV_PCT) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == bvp_pkg::ST_DONE))
    else $error("result word raised outside the output step");
`endif

endmodule

>>> tb/sv/tb_battery_voltage_to_percent.sv
// Self-checking stream testbench for the battery voltage to percent estimator.
module tb_battery_voltage_to_percent;

  typedef struct packed {
    logic                       valid;
    logic [bvp_pkg::VOLT_W-1:0] millivolts;
    logic [bvp_pkg::PCT_W-1:0]  percent;
  } soc_reading_t;

  localparam int IDLE_PCT = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 500;
  localparam logic [bvp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [bvp_pkg::SAMPLE_W-1:0] EDGE_PINS [15] = '{
    12'd0, 12'd4095, 12'd1450, 12'd2175, 12'd1449, 12'd2176, 12'd2100, 12'd2101,
    12'd1650, 12'd1651, 12'd2050, 12'd1950, 12'd1725, 12'd1825, 12'd1800
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  battery_voltage_to_percent uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state and its copy of the configuration.
  logic [bvp_pkg::COUNT_W-1:0] burst_len = bvp_pkg::SAMPLE_COUNT_RST;
  logic [bvp_pkg::GAIN_W-1:0]  divider = bvp_pkg::DIVIDER_GAIN_RST;
  logic [bvp_pkg::GAIN_W-1:0]  calib = bvp_pkg::CALIBRATION_GAIN_RST;
  logic [bvp_pkg::SUM_W-1:0]   acc_sum = '0;
  logic [bvp_pkg::COUNT_W-1:0] acc_index = '0;
  logic [bvp_pkg::COUNT_W-1:0] acc_good = '0;
  logic [bvp_pkg::VOLT_W-1:0]  held_mv = '0;
  logic [bvp_pkg::PCT_W-1:0]   held_pct = '0;

  logic [bvp_pkg::SAMPLE_W-1:0] pending_samples [$];
  soc_reading_t                 expected_readings [$];
  soc_reading_t                 want;
  logic                         in_fire = 1'b0;
  bit                           steady = 1'b0;
  int                           hold_asked = 0;
  int                           hold_granted = 0;
  int                           hold_left = 0;
  int                           stall_cycles = 0;
  int                           mismatch_count = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [bvp_pkg::PCT_W-1:0] charge_from_millivolts(
      input logic [bvp_pkg::VOLT_W-1:0] mv);
    int unsigned hv, lv, hp, lp, dv;
    if (mv >= bvp_pkg::CURVE_MV[0]) return bvp_pkg::CURVE_PCT[0];
    if (mv <= bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1])
      return bvp_pkg::CURVE_PCT[bvp_pkg::CURVE_POINTS-1];
    for (int i = 0; i < bvp_pkg::CURVE_POINTS - 1; i++) begin
      hv = bvp_pkg::CURVE_MV[i];
      lv = bvp_pkg::CURVE_MV[i+1];
      hp = bvp_pkg::CURVE_PCT[i];
      lp = bvp_pkg::CURVE_PCT[i+1];
      if (mv <= hv && mv >= lv) begin
        dv = hv - lv;
        return bvp_pkg::PCT_W'(lp + (2 * (mv - lv) * (hp - lp) + dv) / (2 * dv));
      end
    end
    return '0;
  endfunction

  task automatic absorb_sample(input logic [bvp_pkg::SAMPLE_W-1:0] sample);
    logic [63:0]                 product;
    logic [63:0]                 mv_wide;
    logic [bvp_pkg::COUNT_W-1:0] limit;
    soc_reading_t                r;
    limit = (burst_len == 0) ? bvp_pkg::COUNT_W'(1) : burst_len;
    if (sample != 0) begin
      acc_sum = acc_sum + sample;
      acc_good = acc_good + 1'b1;
    end
    acc_index = acc_index + 1'b1;
    if (acc_index >= limit) begin
      r.valid = 1'b0;
      if (acc_good != 0) begin
        product = 64'(acc_sum) * 64'(divider) * 64'(calib);
        mv_wide = product / (64'(acc_good) << bvp_pkg::FRAC_SHIFT);
        if (mv_wide >= bvp_pkg::MV_LOW && mv_wide <= bvp_pkg::MV_HIGH) begin
          held_mv = mv_wide[bvp_pkg::VOLT_W-1:0];
          held_pct = charge_from_millivolts(held_mv);
          r.valid = 1'b1;
        end
      end
      acc_sum = '0;
      acc_index = '0;
      acc_good = '0;
      r.millivolts = held_mv;
      r.percent = held_pct;
      expected_readings.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) absorb_sample(s_tdata[bvp_pkg::SAMPLE_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result word with none expected");
        end else begin
          want = expected_readings.pop_front();
          if (m_tuser[0] !== want.valid)
            report_mismatch($sformatf("reading_valid %b, expected %b", m_tuser[0], want.valid));
          if (m_tdata[12:0] !== want.millivolts)
            report_mismatch($sformatf("battery_millivolts %0d, expected %0d",
                                      m_tdata[12:0], want.millivolts));
          if (m_tdata[19:13] !== want.percent)
            report_mismatch($sformatf("charge_percent %0d, expected %0d",
                                      m_tdata[19:13], want.percent));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("** battery_voltage_to_percent: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Sample driver: keeps a word up until it is taken, then maybe idles.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_samples.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, pending_samples.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure and requested long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_granted <= hold_granted + 1;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic write_register(input logic [bvp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      bvp_pkg::REG_SAMPLE_COUNT:     burst_len = value[bvp_pkg::COUNT_W-1:0];
      bvp_pkg::REG_DIVIDER_GAIN:     divider = value;
      bvp_pkg::REG_CALIBRATION_GAIN: calib = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_settled();
    do @(posedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queues n samples; mode 0 aims at a battery voltage around the accepted range for the current gains.
  task automatic queue_samples(input int n, input int mode);
    longint target, pin, s;
    target = $urandom_range(2850, 4400);
    pin = 0;
    if (divider != 0 && calib != 0)
      pin = (target << bvp_pkg::FRAC_SHIFT) / (longint'(divider) * longint'(calib));
    if (pin < 1 || pin > 4095) pin = $urandom_range(1, 4095);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: s = ($urandom_range(0, 99) < 6) ? 0 : pin + $urandom_range(0, 6) - 3;
        1: s = 0;
        2: s = ($urandom_range(0, 1) == 0) ? 0 : pin + $urandom_range(0, 20) - 10;
        default: s = $urandom_range(0, 4095);
      endcase
      if (mode != 1 && mode != 3 && s < 1) s = 1;
      if (s > 4095) s = 4095;
      pending_samples.push_back(bvp_pkg::SAMPLE_W'(s));
    end
  endtask

  initial begin
    int sent, phase, eff, n, mode, pick;
    logic [15:0] dg, cg, sc;
    sent = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window edges, curve points and rounding at nominal gains (pin x2 = battery).
    write_register(bvp_pkg::REG_SAMPLE_COUNT, 16'd1);
    write_register(bvp_pkg::REG_DIVIDER_GAIN, 16'd8192);
    write_register(bvp_pkg::REG_CALIBRATION_GAIN, 16'd4096);
    foreach (EDGE_PINS[i]) pending_samples.push_back(EDGE_PINS[i]);
    wait_until_settled();
    // A zero gain gives zero volts, so the reading is invalid.
    write_register(bvp_pkg::REG_DIVIDER_GAIN, 16'd0);
    pending_samples.push_back(12'd2000);
    wait_until_settled();
    write_register(bvp_pkg::REG_DIVIDER_GAIN, 16'hFFFF);
    write_register(bvp_pkg::REG_CALIBRATION_GAIN, 16'hFFFF);
    pending_samples.push_back(12'd12);
    wait_until_settled();
    write_register(bvp_pkg::REG_CALIBRATION_GAIN, 16'd1);
    pending_samples.push_back(12'd4095);
    wait_until_settled();
    // A sample count of zero behaves as one.
    write_register(bvp_pkg::REG_DIVIDER_GAIN, 16'd8192);
    write_register(bvp_pkg::REG_CALIBRATION_GAIN, 16'd4096);
    write_register(bvp_pkg::REG_SAMPLE_COUNT, 16'd0);
    pending_samples.push_back(12'd1900);
    wait_until_settled();
    // Shrinking the count below the samples already taken ends the burst on the next word.
    write_register(bvp_pkg::REG_SAMPLE_COUNT, 16'd8);
    queue_samples(5, 0);
    wait_until_settled();
    write_register(bvp_pkg::REG_SAMPLE_COUNT, 16'd3);
    write_register(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
    queue_samples(1, 0);
    wait_until_settled();

    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        dg = 16'($urandom_range(6000, 10000));
        cg = 16'($urandom_range(3600, 4600));
      end else if (pick < 80) begin
        dg = 16'($urandom_range(1, 65535));
        cg = 16'($urandom_range(1, 65535));
      end else if (pick < 92) begin
        dg = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
        cg = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
      end else begin
        dg = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd8192;
        cg = (dg == 0) ? 16'd4096 : 16'd0;
      end
      pick = $urandom_range(0, 99);
      if (phase == 2) sc = 16'd1;
      else if (phase == 6) sc = 16'd255;
      else if (pick < 8) sc = 16'd0;
      else if (pick < 75) sc = 16'($urandom_range(1, 8));
      else sc = 16'($urandom_range(9, 40));
      sc[15:8] = 8'($urandom_range(0, 255));
      steady = (phase % 5 == 4);
      write_register(bvp_pkg::REG_SAMPLE_COUNT, sc);
      write_register(bvp_pkg::REG_DIVIDER_GAIN, dg);
      write_register(bvp_pkg::REG_CALIBRATION_GAIN, cg);
      eff = (sc[7:0] == 0) ? 1 : sc[7:0];
      if (phase == 2) begin
        n = 24;
        hold_asked = hold_asked + 1;
      end else if (phase == 6) begin
        n = 255;
      end else begin
        n = eff * $urandom_range(1, 3) + $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 99);
      mode = (pick < 70 || phase == 6) ? 0 : (pick < 80) ? 1 : (pick < 88) ? 2 : 3;
      queue_samples(n, mode);
      sent += n;
      phase++;
      wait_until_settled();
    end

    steady = 1'b0;
    if (expected_readings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
    if (mismatch_count == 0) begin
      $display("** battery_voltage_to_percent: PASSED **");
    end else begin
      $display("** battery_voltage_to_percent: FAILED **");
    end
    $finish;
  end

endmodule
